// File: hw/rtl/utpq_pkg.sv
// types and constants shared by the task priority queue modules
`timescale 1ns / 1ps

package utpq_pkg;

    localparam int KEY_W = 48;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_EDIT   = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_EXEC   = 2'd3;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_EMPTY  = 2'd1;
    localparam logic [1:0] STAT_ABSENT = 2'd2;
    localparam logic [1:0] STAT_FULL   = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] task_id;
        logic [15:0] user_id;
        logic [31:0] priority_req;
    } cmd_t;

    typedef struct packed {
        logic [15:0] top_user;
        logic        found;
        logic [1:0]  status;
    } result_t;

    // key is {priority, task id}: larger key ranks first
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [15:0]      user;
    } entry_t;

    typedef struct packed {
        logic             match_en;
        logic [15:0]      match_id;
        logic             apply;
        logic             del_en;
        logic [KEY_W-1:0] del_key;
        logic             ins_en;
        logic [KEY_W-1:0] ins_key;
        logic [15:0]      ins_user;
    } bcast_t;

    typedef struct packed {
        entry_t ent;
        logic   gt;
        logic   dle;
        logic   hit;
    } link_t;

endpackage

// File: hw/rtl/utpq_cell.sv
// one cell of the sorted task chain
`timescale 1ns / 1ps

module utpq_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  utpq_pkg::bcast_t bc,
    input  utpq_pkg::link_t  prev_l,
    input  utpq_pkg::link_t  next_l,
    output utpq_pkg::link_t  own_l
);

    logic                       valid_reg;
    logic [utpq_pkg::KEY_W-1:0] key_reg;
    logic [15:0]                user_reg;
    logic                       hit_reg;

    utpq_pkg::entry_t own_ent, a_cur, a_prv, ins_ent, ent_next;
    logic gt_own, dle_own, g_cur, g_prv;

    always_comb begin
        own_ent  = '{valid: valid_reg, key: key_reg, user: user_reg};
        ins_ent  = '{valid: 1'b1, key: bc.ins_key, user: bc.ins_user};
        gt_own   = bc.ins_en && (!valid_reg || (bc.ins_key > key_reg));
        dle_own  = bc.del_en && (!valid_reg || (key_reg <= bc.del_key));
        own_l    = '{ent: own_ent, gt: gt_own, dle: dle_own, hit: hit_reg};
        // chain after the delete, at this place and one place up
        a_cur    = dle_own ? next_l.ent : own_ent;
        g_cur    = dle_own ? next_l.gt : gt_own;
        a_prv    = prev_l.dle ? own_ent : prev_l.ent;
        g_prv    = prev_l.dle ? gt_own : prev_l.gt;
        ent_next = g_cur ? (g_prv ? a_prv : ins_ent) : a_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            if (bc.match_en) begin
                hit_reg <= valid_reg && (key_reg[15:0] == bc.match_id);
            end
            if (bc.apply) begin
                valid_reg <= ent_next.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (bc.apply) begin
            key_reg  <= ent_next.key;
            user_reg <= ent_next.user;
        end
    end

endmodule

// File: hw/rtl/updatable_task_priority_queue.sv
// Task priority queue with add, edit, remove and execute-top commands.
//
// s_valid/s_ready/s_payload carry one command transaction (mode, task id,
// user id, priority). m_valid/m_ready/m_payload return exactly one result
// per command: user of the executed task, found flag and status.
// Tasks sit in a chain of TASK_SLOTS cells kept sorted by priority, then
// task id, highest first; cell 0 always holds the top task.
// For each command the cells compare the task id on acceptance,
// the hit cell is gathered into a delete/insert pair, then every cell
// shifts or takes the new entry in one step. One command is in flight at
// a time: a new command is accepted only after the last one is applied.
// The result sits in an output register; a stalled receiver holds the
// apply step until the register frees, and no new command is accepted
// until then.
// Reset (aresetn low, synchronous) empties the chain and drops any
// pending result.
`timescale 1ns / 1ps

module updatable_task_priority_queue #(
    parameter int TASK_SLOTS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  utpq_pkg::cmd_t    s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output utpq_pkg::result_t m_payload
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_GATHER = 3'b010,
        ST_APPLY  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    utpq_pkg::cmd_t    cmd_reg;
    utpq_pkg::result_t res_reg, res_next;
    utpq_pkg::result_t m_payload_reg;
    logic              m_valid_reg;

    logic                       del_en_reg, del_en_next;
    logic [utpq_pkg::KEY_W-1:0] del_key_reg, del_key_next;
    logic                       ins_en_reg, ins_en_next;
    logic [utpq_pkg::KEY_W-1:0] ins_key_reg, ins_key_next;
    logic [15:0]                ins_user_reg, ins_user_next;

    utpq_pkg::bcast_t bc;
    utpq_pkg::link_t  links [TASK_SLOTS];
    utpq_pkg::link_t  prev_in [TASK_SLOTS];
    utpq_pkg::link_t  next_in [TASK_SLOTS];

    logic             hit_any;
    utpq_pkg::entry_t hit_ent;
    logic             s_accept;
    logic             apply_go;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign apply_go  = (state_reg == ST_APPLY) && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    always_comb begin
        bc.match_en = s_accept;
        bc.match_id = s_payload.task_id;
        bc.apply    = apply_go;
        bc.del_en   = del_en_reg;
        bc.del_key  = del_key_reg;
        bc.ins_en   = ins_en_reg;
        bc.ins_key  = ins_key_reg;
        bc.ins_user = ins_user_reg;
    end

    always_comb begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
            prev_in[i] = (i == 0) ? '0 : links[(i == 0) ? 0 : i - 1];
            if (i == TASK_SLOTS - 1) begin
                next_in[i]    = '0;
                next_in[i].gt = ins_en_reg;
            end else begin
                next_in[i] = links[(i == TASK_SLOTS - 1) ? i : i + 1];
            end
        end
    end

    for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
        utpq_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .bc      (bc),
            .prev_l  (prev_in[g]),
            .next_l  (next_in[g]),
            .own_l   (links[g])
        );
    end

    // ids are unique, so at most one cell hits
    always_comb begin
        hit_any = 1'b0;
        hit_ent = '0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            hit_any = hit_any | links[i].hit;
            hit_ent = hit_ent | (links[i].ent & {$bits(utpq_pkg::entry_t){links[i].hit}});
        end
    end

    always_comb begin
        state_next    = state_reg;
        del_en_next   = del_en_reg;
        del_key_next  = del_key_reg;
        ins_en_next   = ins_en_reg;
        ins_key_next  = ins_key_reg;
        ins_user_next = ins_user_reg;
        res_next      = res_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_GATHER;
                end
            end
            ST_GATHER: begin
                del_en_next   = 1'b0;
                del_key_next  = hit_ent.key;
                ins_en_next   = 1'b0;
                ins_key_next  = {cmd_reg.priority_req, cmd_reg.task_id};
                ins_user_next = cmd_reg.user_id;
                res_next      = '{top_user: 16'd0, found: 1'b0,
                                  status: utpq_pkg::STAT_OK};
                case (cmd_reg.mode)
                    utpq_pkg::MODE_ADD: begin
                        if (hit_any) begin
                            del_en_next = 1'b1;
                            ins_en_next = 1'b1;
                        end else if (links[TASK_SLOTS-1].ent.valid) begin
                            res_next.status = utpq_pkg::STAT_FULL;
                        end else begin
                            ins_en_next = 1'b1;
                        end
                    end
                    utpq_pkg::MODE_EDIT: begin
                        ins_user_next = hit_ent.user;
                        if (hit_any) begin
                            del_en_next = 1'b1;
                            ins_en_next = 1'b1;
                        end else begin
                            res_next.status = utpq_pkg::STAT_ABSENT;
                        end
                    end
                    utpq_pkg::MODE_REMOVE: begin
                        if (hit_any) begin
                            del_en_next = 1'b1;
                        end else begin
                            res_next.status = utpq_pkg::STAT_ABSENT;
                        end
                    end
                    default: begin
                        del_key_next = links[0].ent.key;
                        if (links[0].ent.valid) begin
                            del_en_next       = 1'b1;
                            res_next.top_user = links[0].ent.user;
                            res_next.found    = 1'b1;
                        end else begin
                            res_next.status = utpq_pkg::STAT_EMPTY;
                        end
                    end
                endcase
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (apply_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            del_en_reg  <= 1'b0;
            ins_en_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            del_en_reg <= del_en_next;
            ins_en_reg <= ins_en_next;
            if (apply_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg <= s_payload;
        end
        if (apply_go) begin
            m_payload_reg <= res_reg;
        end
        del_key_reg  <= del_key_next;
        ins_key_reg  <= ins_key_next;
        ins_user_reg <= ins_user_next;
        res_reg      <= res_next;
    end

endmodule
